>>> design/acf_pkg.sv
// Package for the attitude filter core: state, phase and selector types,
// register indexes, fixed-point constants and small shared helpers.
// No dependencies.
package acf_pkg;

	// configuration register indexes
	localparam logic [7:0] REG_KP_GAIN   = 8'd0;
	localparam logic [7:0] REG_MAX_DT_US = 8'd1;
	localparam logic [7:0] REG_ACCEL_MIN = 8'd2;
	localparam logic [7:0] REG_ACCEL_MAX = 8'd3;

	// register reset values
	localparam logic [23:0] KP_GAIN_RST   = 24'd131072;
	localparam logic [19:0] MAX_DT_RST    = 20'd50000;
	localparam logic [19:0] ACCEL_MIN_RST = 20'd39322;
	localparam logic [19:0] ACCEL_MAX_RST = 20'd91750;

	// step sizes in microseconds
	localparam logic [19:0] DT_FIRST  = 20'd10000;
	localparam logic [31:0] DT_NONPOS = 32'd1000;

	// half-angle scaling: omega*dt*512/62500, rounded half away from zero
	localparam logic [31:0] HALF_DEN = 32'd62500;
	localparam logic [63:0] HALF_RND = 64'd31250;

	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic signed [63:0] ONE_Q60 = 64'sh1000_0000_0000_0000;

	// product signs: gravity (w*y, x*z, w*x, y*z, x*x, y*y) and q*dq
	localparam logic [5:0]  GRAV_NEG = 6'b001110;
	localparam logic [15:0] QMUL_NEG = 16'h428E;

	// serial unit operand width and step counts
	localparam int unsigned MUL_W      = 34;
	localparam int unsigned MUL_STEPS  = 34;
	localparam int unsigned DIV_STEPS  = 64;
	localparam int unsigned SQRT_STEPS = 32;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MGO, ST_MWAIT, ST_SGO, ST_SWAIT, ST_DGO, ST_DWAIT,
		ST_NABS, ST_NSHIFT, ST_NDONE, ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		PH_ASQ, PH_GRAV, PH_ERR, PH_CORR, PH_HALF, PH_NSQ, PH_QMUL
	} phase_t;

	// which vector the normaliser is working on
	typedef enum logic [1:0] {NS_G, NS_A, NS_D, NS_Q} nsel_t;

	typedef struct packed {
		logic s_ready;
		logic mul_go;
		logic sqrt_go;
		logic div_go;
	} ctl_t;

	function automatic logic signed [MUL_W-1:0] sx32(input logic signed [31:0] v);
		sx32 = {{(MUL_W-32){v[31]}}, v};
	endfunction

	// round half up from Q.60 to Q.30
	function automatic logic signed [63:0] round30(input logic signed [63:0] v);
		logic signed [63:0] s;
		s = v + 64'sh2000_0000;
		round30 = s >>> 30;
	endfunction

endpackage

>>> design/acf_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, sign-magnitude.
// Depends on acf_pkg.
module acf_mul import acf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [MUL_W-1:0] a,
	input  logic signed [MUL_W-1:0] b,
	output logic                    done,
	output logic signed [63:0]      prod
);

	logic             busy_q, done_q, neg_q;
	logic [5:0]       cnt_q;
	logic [63:0]      a_q, p_q;
	logic [MUL_W-1:0] b_q, amag, bmag;

	assign amag = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
	assign bmag = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);

	// count steps and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(MUL_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// add the shifted multiplicand for each set multiplier bit
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= 64'(amag);
			b_q   <= bmag;
			p_q   <= '0;
			neg_q <= a[MUL_W-1] ^ b[MUL_W-1];
		end else if (busy_q) begin
			if (b_q[0]) p_q <= p_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = neg_q ? -$signed(p_q) : $signed(p_q);

endmodule

>>> design/acf_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Depends on acf_pkg.
module acf_div import acf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [63:0] quo
);

	logic        busy_q, done_q, ge;
	logic [6:0]  cnt_q;
	logic [63:0] n_q;
	logic [31:0] den_q, rem_q;
	logic [32:0] r;

	assign r  = {rem_q, n_q[63]};
	assign ge = r >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the dividend in, the quotient bits in behind it
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(r - {1'b0, den_q}) : r[31:0];
			n_q   <= {n_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = n_q;

endmodule

>>> design/acf_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on acf_pkg.
module acf_sqrt import acf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] rad,
	output logic        done,
	output logic [31:0] root
);

	logic        busy_q, done_q, ge;
	logic [5:0]  cnt_q;
	logic [63:0] v_q;
	logic [31:0] root_q;
	logic [33:0] rem_q;
	logic [35:0] r, trial;

	assign r     = {rem_q, v_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = r >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(SQRT_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// bring down two bits, try to subtract 4*root+1
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? 34'(r - trial) : r[33:0];
			root_q <= {root_q[30:0], ge};
			v_q    <= v_q << 2;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> design/imu_attitude_complementary_filter_core.sv
// Top level of the attitude filter: handshakes, configuration registers,
// sequencer and datapath registers. Depends on acf_pkg, acf_mul, acf_div, acf_sqrt.
//
// channel  direction  signals                        payload
// s_*      in         s_tvalid s_tready s_tdata      gyro x/y/z, accel x/y/z, timestamp
// m_*      out        m_tvalid m_tready m_tdata      quat w/x/y/z; m_tuser accel_used
// cfg_*    in         cfg_valid cfg_ready            cfg_index, cfg_data
//
// One sample without accel correction needs roughly 30 products on the bit-serial
// multiplier, 11 quotients on the 64-step divider and 3 square roots; with it,
// roughly 51 products, 17 quotients and 5 square roots.
// Reset gives identity orientation and register defaults; no clearing pass.
// A finished result waits in the output register; the next sample is taken
// meanwhile, and the sequencer stalls only if a second result would overwrite it.
module imu_attitude_complementary_filter_core import acf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [223:0] s_tdata,  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, timestamp_us
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // quat_w, quat_x, quat_y, quat_z
	output logic [0:0]   m_tuser,  // accel_used
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	state_t state_q, state_d;
	phase_t ph_q;
	nsel_t  nsel_q;
	ctl_t   ctl;

	logic [3:0]  k_q;
	logic [1:0]  idx_q;
	logic        quat_q, dp_rdiv_q, seen_q, ok_q, m_tvalid_q;
	logic [31:0] prev_q;
	logic [23:0] kp_q;
	logic [19:0] maxdt_q, amin_q, amax_q;
	logic signed [31:0] q_q [4];

	logic signed [31:0] accv_q [3];
	logic signed [33:0] om_q [3];
	logic signed [32:0] e_q [3];
	logic signed [31:0] gn_q [3];
	logic signed [31:0] an_q [3];
	logic signed [31:0] dq_q [4];
	logic signed [63:0] v_q [4];
	logic signed [31:0] nv_q [4];
	logic [3:0]         sgn_q;
	logic signed [63:0] sum_q;
	logic [31:0]        nrm_q;
	logic [19:0]        dt_q;
	logic [31:0]        out_q [4];
	logic               used_q;

	logic                    accept, out_free, k_last, grp_end, idx_last;
	logic                    all_zero, hi, lo, pneg, ok_new;
	logic [1:0]              grp_idx;
	logic signed [MUL_W-1:0] opa, opb;
	logic signed [63:0]      prod, sprod, t, t_rnd;
	logic                    mul_done, div_done, sqrt_done;
	logic [63:0]             div_num, quo, v_abs;
	logic [31:0]             div_den, root, dts, dtr;
	logic [19:0]             dt_new;
	state_t                  exit_st;

	assign accept    = s_tvalid && ctl.s_ready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = ctl.s_ready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {out_q[3], out_q[2], out_q[1], out_q[0]};
	assign m_tuser   = used_q;

	// step length from the timestamp difference
	assign dts    = s_tdata[223:192] - prev_q;
	assign dtr    = (dts == 32'd0 || dts[31]) ? DT_NONPOS : dts;
	assign dt_new = !seen_q ? DT_FIRST : ((dtr > {12'd0, maxdt_q}) ? maxdt_q : dtr[19:0]);

	assign ok_new = root > {12'd0, amin_q} && root < {12'd0, amax_q};

	// product loop bookkeeping
	always_comb begin
		k_last  = 1'b0;
		grp_end = 1'b0;
		grp_idx = 2'd0;
		exit_st = ST_MGO;
		case (ph_q)
			PH_ASQ: begin
				k_last  = k_q == 4'd2;
				grp_end = k_last;
				exit_st = ST_SGO;
			end
			PH_GRAV: begin
				k_last  = k_q == 4'd5;
				grp_end = k_q[0];
				grp_idx = k_q[2:1];
				exit_st = ST_NABS;
			end
			PH_ERR: begin
				k_last  = k_q == 4'd5;
				grp_end = k_q[0];
				grp_idx = k_q[2:1];
			end
			PH_CORR: begin
				k_last  = k_q == 4'd2;
				grp_end = 1'b1;
				grp_idx = k_q[1:0];
			end
			PH_HALF: begin
				k_last  = k_q == 4'd2;
				grp_end = 1'b1;
				grp_idx = k_q[1:0];
				exit_st = ST_DGO;
			end
			PH_NSQ: begin
				k_last  = k_q == (quat_q ? 4'd3 : 4'd2);
				grp_end = k_last;
				exit_st = ST_SGO;
			end
			PH_QMUL: begin
				k_last  = k_q == 4'd15;
				grp_end = k_q[1:0] == 2'd3;
				grp_idx = k_q[3:2];
				exit_st = ST_NABS;
			end
			default: begin
				k_last = 1'b1;
			end
		endcase
	end

	// multiplier operand selection
	always_comb begin
		opa  = '0;
		opb  = '0;
		pneg = 1'b0;
		case (ph_q)
			PH_ASQ: begin
				opa = sx32(accv_q[k_q[1:0]]);
				opb = sx32(accv_q[k_q[1:0]]);
			end
			PH_GRAV: begin
				pneg = GRAV_NEG[k_q[2:0]];
				case (k_q[2:0])
					3'd0: begin opa = sx32(q_q[0]); opb = sx32(q_q[2]); end
					3'd1: begin opa = sx32(q_q[1]); opb = sx32(q_q[3]); end
					3'd2: begin opa = sx32(q_q[0]); opb = sx32(q_q[1]); end
					3'd3: begin opa = sx32(q_q[2]); opb = sx32(q_q[3]); end
					3'd4: begin opa = sx32(q_q[1]); opb = sx32(q_q[1]); end
					default: begin opa = sx32(q_q[2]); opb = sx32(q_q[2]); end
				endcase
			end
			PH_ERR: begin
				pneg = k_q[0];
				case (k_q[2:0])
					3'd0: begin opa = sx32(gn_q[1]); opb = sx32(an_q[2]); end
					3'd1: begin opa = sx32(gn_q[2]); opb = sx32(an_q[1]); end
					3'd2: begin opa = sx32(gn_q[2]); opb = sx32(an_q[0]); end
					3'd3: begin opa = sx32(gn_q[0]); opb = sx32(an_q[2]); end
					3'd4: begin opa = sx32(gn_q[0]); opb = sx32(an_q[1]); end
					default: begin opa = sx32(gn_q[1]); opb = sx32(an_q[0]); end
				endcase
			end
			PH_CORR: begin
				opa = $signed({10'd0, kp_q});
				opb = {e_q[k_q[1:0]][32], e_q[k_q[1:0]]};
			end
			PH_HALF: begin
				opa = om_q[k_q[1:0]];
				opb = $signed({14'd0, dt_q});
			end
			PH_NSQ: begin
				opa = $signed(v_q[k_q[1:0]][MUL_W-1:0]);
				opb = $signed(v_q[k_q[1:0]][MUL_W-1:0]);
			end
			PH_QMUL: begin
				pneg = QMUL_NEG[k_q];
				opa  = sx32(q_q[k_q[1:0]]);
				opb  = sx32(dq_q[k_q[3:2] ^ k_q[1:0]]);
			end
			default: begin
				opa = '0;
			end
		endcase
	end

	assign sprod = pneg ? -prod : prod;
	assign t     = sum_q + sprod;
	assign t_rnd = round30(t);

	// divider operands: half-angle rounding or normaliser quotient
	assign v_abs = v_q[idx_q][63] ? 64'(-v_q[idx_q]) : 64'(v_q[idx_q]);
	assign div_num = dp_rdiv_q ? v_abs + HALF_RND
	                           : (64'(v_q[idx_q][33:0]) << 30) + {33'd0, nrm_q[31:1]};
	assign div_den  = dp_rdiv_q ? HALF_DEN : nrm_q;
	assign idx_last = dp_rdiv_q ? (idx_q == 2'd3) : (idx_q == (quat_q ? 2'd3 : 2'd2));

	// range tests for the normalising shift
	always_comb begin
		all_zero = 1'b1;
		hi       = 1'b0;
		lo       = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (v_q[i] != 64'sd0) all_zero = 1'b0;
			if (v_q[i][63:31] != '0) hi = 1'b1;
			if (v_q[i][63:30] != '0) lo = 1'b0;
		end
	end

	acf_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(ctl.mul_go),
		.a(opa), .b(opb), .done(mul_done), .prod(prod)
	);

	acf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_go),
		.num(div_num), .den(div_den), .done(div_done), .quo(quo)
	);

	acf_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(ctl.sqrt_go),
		.rad(sum_q), .done(sqrt_done), .root(root)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_MGO;
			ST_MGO:    state_d = ST_MWAIT;
			ST_MWAIT:  if (mul_done) state_d = k_last ? exit_st : ST_MGO;
			ST_SGO:    state_d = ST_SWAIT;
			ST_SWAIT:  if (sqrt_done) state_d = (ph_q == PH_NSQ) ? ST_DGO : ST_MGO;
			ST_DGO:    state_d = ST_DWAIT;
			ST_DWAIT: begin
				if (div_done) begin
					if (!idx_last) state_d = ST_DGO;
					else state_d = dp_rdiv_q ? ST_NABS : ST_NDONE;
				end
			end
			ST_NABS:   state_d = ST_NSHIFT;
			ST_NSHIFT: begin
				if (all_zero) state_d = ST_NDONE;
				else if (!hi && !lo) state_d = ST_MGO;
			end
			ST_NDONE: begin
				case (nsel_q)
					NS_Q:    state_d = ST_OUT;
					NS_G:    state_d = ST_NABS;
					default: state_d = ST_MGO;
				endcase
			end
			ST_OUT:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// unit starts and input handshake
	always_comb begin
		ctl.s_ready = state_q == ST_IDLE;
		ctl.mul_go  = state_q == ST_MGO;
		ctl.sqrt_go = state_q == ST_SGO;
		ctl.div_go  = state_q == ST_DGO;
	end

	// sequencer, orientation state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ph_q       <= PH_ASQ;
			nsel_q     <= NS_G;
			k_q        <= '0;
			idx_q      <= '0;
			quat_q     <= 1'b0;
			dp_rdiv_q  <= 1'b0;
			seen_q     <= 1'b0;
			prev_q     <= '0;
			m_tvalid_q <= 1'b0;
			kp_q       <= KP_GAIN_RST;
			maxdt_q    <= MAX_DT_RST;
			amin_q     <= ACCEL_MIN_RST;
			amax_q     <= ACCEL_MAX_RST;
			q_q[0]     <= ONE_Q30;
			q_q[1]     <= '0;
			q_q[2]     <= '0;
			q_q[3]     <= '0;
		end else begin
			state_q <= state_d;
			// raise the result flag from the output state, drop it once taken
			if (state_q == ST_OUT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;

			if (cfg_valid) begin
				case (cfg_index)
					REG_KP_GAIN:   kp_q    <= cfg_data;
					REG_MAX_DT_US: maxdt_q <= cfg_data[19:0];
					REG_ACCEL_MIN: amin_q  <= cfg_data[19:0];
					REG_ACCEL_MAX: amax_q  <= cfg_data[19:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ph_q   <= PH_ASQ;
						k_q    <= '0;
						prev_q <= s_tdata[223:192];
						seen_q <= 1'b1;
					end
				end
				ST_MWAIT: begin
					if (mul_done) begin
						if (!k_last) begin
							k_q <= k_q + 4'd1;
						end else begin
							k_q <= '0;
							case (ph_q)
								PH_GRAV: begin nsel_q <= NS_G; quat_q <= 1'b0; end
								PH_ERR:  ph_q <= PH_CORR;
								PH_CORR: ph_q <= PH_HALF;
								PH_HALF: begin dp_rdiv_q <= 1'b1; idx_q <= 2'd1; end
								PH_QMUL: begin nsel_q <= NS_Q; quat_q <= 1'b1; end
								default: ;
							endcase
						end
					end
				end
				ST_SWAIT: begin
					if (sqrt_done) begin
						if (ph_q == PH_ASQ) begin
							ph_q <= ok_new ? PH_GRAV : PH_HALF;
							k_q  <= '0;
						end else begin
							dp_rdiv_q <= 1'b0;
							idx_q     <= '0;
						end
					end
				end
				ST_DWAIT: begin
					if (div_done) begin
						if (!idx_last) begin
							idx_q <= idx_q + 2'd1;
						end else if (dp_rdiv_q) begin
							quat_q <= 1'b1;
							nsel_q <= NS_D;
						end
					end
				end
				ST_NSHIFT: begin
					if (!all_zero && !hi && !lo) begin
						ph_q <= PH_NSQ;
						k_q  <= '0;
					end
				end
				ST_NDONE: begin
					case (nsel_q)
						NS_G: begin nsel_q <= NS_A; quat_q <= 1'b0; end
						NS_A: begin ph_q <= PH_ERR; k_q <= '0; end
						NS_D: begin ph_q <= PH_QMUL; k_q <= '0; end
						default: begin
							for (int i = 0; i < 4; i++) q_q[i] <= nv_q[i];
						end
					endcase
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					for (int i = 0; i < 3; i++) begin
						accv_q[i] <= $signed(s_tdata[96 + 32*i +: 32]);
						om_q[i]   <= sx32($signed(s_tdata[32*i +: 32]));
					end
					dt_q  <= dt_new;
					sum_q <= '0;
				end
			end
			ST_MWAIT: begin
				if (mul_done) begin
					// accumulate, or clear once a grouped result is stored
					case (ph_q)
						PH_GRAV, PH_ERR, PH_CORR, PH_HALF, PH_QMUL:
							sum_q <= grp_end ? 64'sd0 : t;
						default: sum_q <= t;
					endcase
					if (grp_end) begin
						case (ph_q)
							PH_GRAV: begin
								if (grp_idx == 2'd2) v_q[2] <= (t <<< 1) - ONE_Q60;
								else v_q[grp_idx] <= t <<< 1;
							end
							PH_ERR:  e_q[grp_idx] <= $signed(t_rnd[32:0]);
							PH_CORR: om_q[grp_idx] <= om_q[grp_idx] + $signed(t_rnd[33:0]);
							PH_HALF: v_q[2'(grp_idx + 2'd1)] <= t <<< 9;
							PH_QMUL: v_q[grp_idx] <= t;
							default: ;
						endcase
					end
				end
			end
			ST_SWAIT: begin
				if (sqrt_done) begin
					if (ph_q == PH_ASQ) begin
						ok_q  <= ok_new;
						sum_q <= '0;
					end else begin
						nrm_q <= root;
					end
				end
			end
			ST_DWAIT: begin
				if (div_done) begin
					if (dp_rdiv_q) begin
						v_q[idx_q] <= v_q[idx_q][63] ? -$signed(quo) : $signed(quo);
						if (idx_last) v_q[0] <= 64'(ONE_Q30);
					end else begin
						nv_q[idx_q] <= sgn_q[idx_q] ? -$signed(quo[31:0]) : $signed(quo[31:0]);
					end
				end
			end
			ST_NABS: begin
				// keep signs, work on magnitudes; a vector has no fourth element
				for (int i = 0; i < 4; i++) begin
					sgn_q[i] <= v_q[i][63];
					if (i == 3 && !quat_q) v_q[i] <= '0;
					else v_q[i] <= v_q[i][63] ? -v_q[i] : v_q[i];
				end
			end
			ST_NSHIFT: begin
				if (all_zero) begin
					for (int i = 0; i < 4; i++) nv_q[i] <= (i == 0 && quat_q) ? ONE_Q30 : 32'sd0;
				end else if (hi) begin
					for (int i = 0; i < 4; i++) v_q[i] <= $signed(64'(v_q[i]) >> 1);
				end else if (lo) begin
					for (int i = 0; i < 4; i++) v_q[i] <= v_q[i] <<< 1;
				end else begin
					sum_q <= '0;
				end
			end
			ST_NDONE: begin
				sum_q <= '0;
				case (nsel_q)
					NS_G: begin
						for (int i = 0; i < 3; i++) begin
							gn_q[i] <= nv_q[i];
							v_q[i]  <= 64'(accv_q[i]);
						end
						v_q[3] <= '0;
					end
					NS_A: for (int i = 0; i < 3; i++) an_q[i] <= nv_q[i];
					NS_D: for (int i = 0; i < 4; i++) dq_q[i] <= nv_q[i];
					default: ;
				endcase
			end
			ST_OUT: begin
				if (out_free) begin
					for (int i = 0; i < 4; i++) out_q[i] <= q_q[i];
					used_q <= ok_q;
				end
			end
			default: ;
		endcase
	end

	// an accepted sample always starts the product loop
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MGO && ph_q == PH_ASQ && k_q == 4'd0))
		else $error("sample accepted without starting the sequencer");

	// a new result only ever comes from the output state
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output state");

	// the last quaternion product hands a four-element vector to the normaliser
	a_qmul_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MWAIT && mul_done && k_last && ph_q == PH_QMUL)
		|=> (state_q == ST_NABS && quat_q && nsel_q == NS_Q))
		else $error("quaternion product not passed to the normaliser");

endmodule

>>> tb/testbench.sv
// Testbench for imu_attitude_complementary_filter_core: drives IMU samples and
// register writes, predicts each orientation result and checks it field by field.
// Depends on acf_pkg and the core RTL.
module testbench;
	import acf_pkg::*;

	typedef struct {
		logic signed [31:0] gyro [3];
		logic signed [31:0] accel [3];
		logic [31:0]        stamp;
	} sample_t;

	typedef struct {
		logic signed [31:0] quat [4];
		logic               used;
	} attitude_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [223:0] s_tdata;  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, timestamp_us
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;  // quat_w, quat_x, quat_y, quat_z
	logic [0:0]   m_tuser;  // accel_used
	logic         cfg_valid;
	logic         cfg_ready;
	logic [7:0]   cfg_index;
	logic [23:0]  cfg_data;

	// predictor copy of registers and filter state
	logic [23:0] gain_q16;
	logic [19:0] dt_cap;
	logic [19:0] band_lo;
	logic [19:0] band_hi;
	longint      att [4];
	logic [31:0] last_stamp;
	bit          stamp_valid;

	// expected results in order, as a ring with write and read counts
	attitude_t   pending_buf [1024];
	int          wr_count;
	int          rd_count;
	int          mismatches;
	bit          sender_steady;
	bit          receiver_steady;
	bit          hold_request;
	int          hold_left;
	logic [31:0] stamp_now;

	imu_attitude_complementary_filter_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// fixed-point helpers for the predictor
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] rem, root, b;
		rem = v;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic longint round_q30(input longint v);
		return (v + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint div_round(input longint num, input longint den);
		logic [63:0] mag, q;
		mag = num < 0 ? -num : num;
		q = (mag + den / 2) / den;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	// scale to unit length in Q2.30; zero gives zero, or identity for a quaternion
	task automatic unit_vector(input longint v [4], input int n, input bit quat,
			output longint r [4]);
		logic [63:0] m [4];
		logic [63:0] mx, sum, nrm, q;
		mx = 0;
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			r[i] = 0;
			m[i] = 0;
		end
		for (int i = 0; i < n; i++) begin
			m[i] = v[i] < 0 ? -v[i] : v[i];
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			if (quat) r[0] = 64'sd1 <<< 30;
			return;
		end
		while (mx >= (64'd1 << 31)) begin
			mx = mx >> 1;
			for (int i = 0; i < n; i++) m[i] = m[i] >> 1;
		end
		while (mx < (64'd1 << 30)) begin
			mx = mx << 1;
			for (int i = 0; i < n; i++) m[i] = m[i] << 1;
		end
		for (int i = 0; i < n; i++) sum = sum + m[i] * m[i];
		nrm = int_sqrt(sum);
		for (int i = 0; i < n; i++) begin
			q = ((m[i] << 30) + nrm / 2) / nrm;
			r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
	endtask

	// advance the orientation by one sample and return the expected result
	task automatic advance_attitude(input sample_t s, output attitude_t r);
		longint omega [3], acc [3], gv [4], gn [4], an [4], av [4], p [4], dq [4];
		longint e [3];
		longint w, x, y, z;
		logic [31:0] d;
		logic [63:0] dt, sum, mag, mm;
		bit ok;
		if (!stamp_valid) begin
			dt = 64'(DT_FIRST);
		end else begin
			d = s.stamp - last_stamp;
			dt = (d == 0 || d[31]) ? 64'(DT_NONPOS) : 64'(d);
			if (dt > 64'(dt_cap)) dt = 64'(dt_cap);
		end
		last_stamp = s.stamp;
		stamp_valid = 1;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			acc[i] = s.accel[i];
			omega[i] = s.gyro[i];
			mm = acc[i] < 0 ? -acc[i] : acc[i];
			sum = sum + mm * mm;
		end
		mag = int_sqrt(sum);
		ok = (mag > 64'(band_lo)) && (mag < 64'(band_hi));
		w = att[0]; x = att[1]; y = att[2]; z = att[3];
		if (ok) begin
			gv[0] = 2 * (w * y - x * z);
			gv[1] = -2 * (w * x + y * z);
			gv[2] = 2 * (x * x + y * y) - (64'sd1 <<< 60);
			gv[3] = 0;
			av[0] = acc[0]; av[1] = acc[1]; av[2] = acc[2]; av[3] = 0;
			unit_vector(gv, 3, 0, gn);
			unit_vector(av, 3, 0, an);
			e[0] = round_q30(gn[1] * an[2] - gn[2] * an[1]);
			e[1] = round_q30(gn[2] * an[0] - gn[0] * an[2]);
			e[2] = round_q30(gn[0] * an[1] - gn[1] * an[0]);
			for (int i = 0; i < 3; i++)
				omega[i] = omega[i] + round_q30(longint'(gain_q16) * e[i]);
		end
		p[0] = 64'sd1 <<< 30;
		for (int i = 0; i < 3; i++)
			p[1 + i] = div_round(omega[i] * longint'(dt) * 512, 62500);
		unit_vector(p, 4, 1, dq);
		p[0] = w * dq[0] - x * dq[1] - y * dq[2] - z * dq[3];
		p[1] = w * dq[1] + x * dq[0] + y * dq[3] - z * dq[2];
		p[2] = w * dq[2] - x * dq[3] + y * dq[0] + z * dq[1];
		p[3] = w * dq[3] + x * dq[2] - y * dq[1] + z * dq[0];
		unit_vector(p, 4, 1, att);
		for (int i = 0; i < 4; i++) r.quat[i] = att[i][31:0];
		r.used = ok;
	endtask

	// offer one sample, with random idle cycles unless the sender is steady
	task automatic send_sample(input sample_t s);
		attitude_t r;
		@(negedge clk);
		while (!sender_steady && $urandom_range(0, 99) < 26) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {s.stamp, s.accel[2], s.accel[1], s.accel[0],
			s.gyro[2], s.gyro[1], s.gyro[0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		advance_attitude(s, r);
		pending_buf[wr_count % 1024] = r;
		wr_count++;
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [23:0] value);
		@(negedge clk);
		s_tvalid = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_KP_GAIN:   gain_q16 = value;
			REG_MAX_DT_US: dt_cap = value[19:0];
			REG_ACCEL_MIN: band_lo = value[19:0];
			REG_ACCEL_MAX: band_hi = value[19:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid = 1'b0;
		while (wr_count != rd_count) @(posedge clk);
	endtask

	function automatic sample_t make_sample(input logic signed [31:0] gx,
			input logic signed [31:0] gy, input logic signed [31:0] gz,
			input logic signed [31:0] ax, input logic signed [31:0] ay,
			input logic signed [31:0] az, input logic [31:0] stamp);
		sample_t s;
		s.gyro[0] = gx; s.gyro[1] = gy; s.gyro[2] = gz;
		s.accel[0] = ax; s.accel[1] = ay; s.accel[2] = az;
		s.stamp = stamp;
		return s;
	endfunction

	// mostly plausible motion near 1 g, some pure noise, odd timestamps now and then
	function automatic sample_t random_sample();
		sample_t s;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			for (int i = 0; i < 3; i++) begin
				s.gyro[i] = $urandom;
				s.accel[i] = $urandom;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				s.gyro[i] = int'($urandom_range(0, 1 << 19)) - (1 << 18);
				s.accel[i] = int'($urandom_range(0, 60000)) - 30000;
			end
			s.accel[$urandom_range(0, 2)] = ($urandom_range(0, 1) ? 1 : -1)
				* int'($urandom_range(30000, 100000));
		end
		pick = $urandom_range(0, 99);
		if (pick < 82) stamp_now = stamp_now + $urandom_range(500, 20000);
		else if (pick < 86) stamp_now = stamp_now;
		else if (pick < 91) stamp_now = stamp_now - $urandom_range(1, 5000);
		else if (pick < 95) stamp_now = stamp_now + 32'h8000_0000;
		else stamp_now = $urandom;
		s.stamp = stamp_now;
		return s;
	endfunction

	// extremes of every field and the timing special cases
	task automatic test_directed;
		stamp_now = 32'hFFFF_F000;
		// first sample after reset, accel level at 1 g
		send_sample(make_sample(0, 0, 0, 0, 0, 32'sd65536, stamp_now));
		send_sample(make_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1000, 0, 32'sd65536, 0,
			stamp_now + 5000));
		// repeated timestamp, then one going backwards, then a wrap past zero
		send_sample(make_sample(32'sd65536, 0, 0, 32'sd40000, 0, 32'sd40000, stamp_now + 5000));
		send_sample(make_sample(0, 32'sd65536, 0, 0, 0, -32'sd65536, stamp_now + 100));
		send_sample(make_sample(0, 0, 32'sd65536, 32'sd39322, 0, 0, stamp_now + 32'h2000));
		// huge interval hits the cap; accel extremes and zero vector
		send_sample(make_sample(-32'sd1, -32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'h7000_0000));
		send_sample(make_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0,
			32'h7000_0000 + 32'h7FFF_FFFF));
		send_sample(make_sample(0, 0, 0, 32'sd91750, 0, 0, 32'h7000_1000));
		send_sample(make_sample(0, 0, 0, 32'sd91749, 0, 0, 32'h7000_2000));
		send_sample(make_sample(0, 0, 0, 32'sd39323, 0, 0, 32'h7000_3000));
		drain();
		// full gain, longest cap, widest band
		write_reg(REG_KP_GAIN, 24'hFF_FFFF);
		write_reg(REG_MAX_DT_US, 24'hF0_0000 | 24'd1000000);
		write_reg(REG_ACCEL_MIN, 24'd0);
		write_reg(REG_ACCEL_MAX, 24'hFF_FFFF);
		write_reg(8'd5, 24'd7);
		send_sample(make_sample(32'sd3000, -32'sd2000, 32'sd100, 32'sd20000, -32'sd50000,
			32'sd30000, 32'h7010_0000));
		send_sample(make_sample(0, 0, 0, 32'sd1, 0, 0, 32'hF000_0000));
		send_sample(make_sample(0, 0, 0, 0, -32'sd65536, 0, 32'hF000_0400));
		drain();
		// no gain, one microsecond cap, empty band
		write_reg(REG_KP_GAIN, 24'd0);
		write_reg(REG_MAX_DT_US, 24'd1);
		write_reg(REG_ACCEL_MIN, 24'd70000);
		write_reg(REG_ACCEL_MAX, 24'd70000);
		send_sample(make_sample(32'sh7FFF_FFFF, 0, 0, 0, 0, 32'sd70000, 32'hF000_9000));
		send_sample(make_sample(0, 32'sh7FFF_FFFF, 0, 0, 0, 32'sd65536, 32'hF001_0000));
		drain();
		stamp_now = 32'hF001_0000;
	endtask

	// random samples across several register settings
	task automatic test_random;
		logic [23:0] gains [6];
		logic [19:0] caps [6], lows [6], highs [6];
		gains = '{24'd131072, 24'hFF_FFFF, 24'd0, 24'd6553, 24'd131072, 24'd500000};
		caps  = '{20'd50000, 20'd1000000, 20'd1, 20'd20000, 20'd3000, 20'd50000};
		lows  = '{20'd39322, 20'd0, 20'd39322, 20'd60000, 20'd90000, 20'hF_FFFF};
		highs = '{20'd91750, 20'hF_FFFF, 20'd91750, 20'd70000, 20'd40000, 20'hF_FFFF};
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_KP_GAIN, gains[ph]);
			write_reg(REG_MAX_DT_US, {4'h0, caps[ph]});
			write_reg(REG_ACCEL_MIN, {4'h0, lows[ph]});
			write_reg(REG_ACCEL_MAX, {4'h0, highs[ph]});
			sender_steady = (ph == 3);
			receiver_steady = (ph == 3);
			for (int k = 0; k < 100; k++) send_sample(random_sample());
			drain();
		end
		sender_steady = 0;
		receiver_steady = 0;
	endtask

	// receiver holds off long enough for the core to fill and stall its input
	task automatic test_backpressure;
		write_reg(REG_KP_GAIN, 24'd131072);
		write_reg(REG_MAX_DT_US, 24'd50000);
		write_reg(REG_ACCEL_MIN, 24'd39322);
		write_reg(REG_ACCEL_MAX, 24'd91750);
		sender_steady = 1;
		hold_request = 1;
		for (int k = 0; k < 6; k++) send_sample(random_sample());
		sender_steady = 0;
		drain();
	endtask

	// receiver ready: long hold-off on request, otherwise random stalls
	initial begin
		m_tready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 0;
				hold_left = 15000;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				m_tready = receiver_steady || ($urandom_range(0, 99) >= 26);
			end
		end
	end

	// compare each result with the oldest expectation
	initial begin
		attitude_t want;
		logic signed [31:0] got [4];
		bit bad;
		mismatches = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				for (int i = 0; i < 4; i++) got[i] = m_tdata[32 * i +: 32];
				if (wr_count == rd_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: quat %h %h %h %h used %0d",
							got[0], got[1], got[2], got[3], m_tuser);
				end else begin
					want = pending_buf[rd_count % 1024];
					rd_count++;
					bad = (m_tuser[0] !== want.used);
					for (int i = 0; i < 4; i++) bad = bad || (got[i] !== want.quat[i]);
					if (bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h %h %h %h used %0d, got %h %h %h %h used %0d",
								want.quat[0], want.quat[1], want.quat[2], want.quat[3],
								want.used, got[0], got[1], got[2], got[3], m_tuser);
					end
				end
			end
		end
	end

	initial begin
		#100_000_000;
		$display("imu_attitude_complementary_filter_core test failed");
		$finish;
	end

	initial begin
		wr_count = 0;
		rd_count = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sender_steady = 0;
		receiver_steady = 0;
		hold_request = 0;
		gain_q16 = KP_GAIN_RST;
		dt_cap = MAX_DT_RST;
		band_lo = ACCEL_MIN_RST;
		band_hi = ACCEL_MAX_RST;
		att[0] = 64'sd1 <<< 30;
		att[1] = 0; att[2] = 0; att[3] = 0;
		last_stamp = 0;
		stamp_valid = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		test_backpressure();
		drain();
		repeat (4000) @(posedge clk);
		if (mismatches == 0 && wr_count == rd_count) begin
			$display("imu_attitude_complementary_filter_core test passed");
		end else begin
			$display("imu_attitude_complementary_filter_core test failed");
		end
		$finish;
	end

endmodule
